// ----- hw/rtl/itu_pkg.sv -----
// ============================================================================
// itu_pkg
// Shared types and constants of the interrupt and timer unit.
// ============================================================================
package itu_pkg;

    localparam int PcWidth     = 12;
    localparam int StatusWidth = 3;
    localparam int TimerWidth  = 32;
    localparam int OpWidth     = 2;
    localparam int CfgAddrWidth = 4;
    localparam int CfgDataWidth = 32;

    // Request operation codes.
    localparam logic [OpWidth-1:0] OP_TICK   = 2'd0;
    localparam logic [OpWidth-1:0] OP_RETURN = 2'd1;
    localparam logic [OpWidth-1:0] OP_CLEAR  = 2'd2;

    // Configuration register indexes (byte address is four times the index).
    localparam logic [1:0] REG_TIMER_ENABLE    = 2'd0;
    localparam logic [1:0] REG_TIMER_LIMIT     = 2'd1;
    localparam logic [1:0] REG_IRQ_ENABLE_MASK = 2'd2;
    localparam logic [1:0] REG_HANDLER_ADDRESS = 2'd3;

    // Status bit positions.
    localparam int StatusTimer = 0;
    localparam int StatusDisk  = 1;
    localparam int StatusExt   = 2;

    typedef struct packed {
        logic [OpWidth-1:0]     operation;
        logic [PcWidth-1:0]     pc;
        logic                   disk_done;
        logic                   external_line;
        logic [StatusWidth-1:0] clear_mask;
    } itu_in_t;

    typedef struct packed {
        logic [PcWidth-1:0]     next_pc;
        logic                   interrupt_taken;
        logic [StatusWidth-1:0] status_out;
        logic [TimerWidth-1:0]  timer_out;
        logic                   busy_handling;
    } itu_out_t;

    typedef struct packed {
        logic                   timer_enable;
        logic [TimerWidth-1:0]  timer_limit;
        logic [StatusWidth-1:0] irq_enable_mask;
        logic [PcWidth-1:0]     handler_address;
    } itu_cfg_t;

    typedef struct packed {
        logic [TimerWidth-1:0]  timer_count;
        logic [StatusWidth-1:0] pending_status;
        logic [PcWidth-1:0]     return_address;
        logic                   handling;
    } itu_state_t;

endpackage

// ----- hw/rtl/itu_step.sv -----
// ============================================================================
// itu_step
// Next-state and result logic for one request of the interrupt unit.
// ============================================================================
module itu_step (
    input  itu_pkg::itu_cfg_t   cfg,
    input  itu_pkg::itu_state_t cur,
    input  itu_pkg::itu_in_t    req,
    output itu_pkg::itu_state_t nxt,
    output itu_pkg::itu_out_t   res
);
    import itu_pkg::*;

    logic [StatusWidth-1:0] status_tick;
    logic                   timer_wrap;
    logic                   take_irq;

    always_comb
    begin
        nxt         = cur;
        res.next_pc = req.pc;
        res.interrupt_taken = 1'b0;
        status_tick = cur.pending_status;
        timer_wrap  = cfg.timer_enable && !(cur.timer_count < cfg.timer_limit);
        take_irq    = 1'b0;

        unique case (req.operation)
            OP_TICK:
            begin
                if (cfg.timer_enable)
                begin
                    nxt.timer_count = timer_wrap ? '0 : cur.timer_count + 32'd1;
                end
                status_tick[StatusTimer] = status_tick[StatusTimer] | timer_wrap;
                status_tick[StatusDisk]  = status_tick[StatusDisk] | req.disk_done;
                if (!cur.handling)
                begin
                    status_tick[StatusExt] = status_tick[StatusExt] | req.external_line;
                    take_irq = (status_tick & cfg.irq_enable_mask) != '0;
                end
                nxt.pending_status = status_tick;
                if (take_irq)
                begin
                    nxt.handling        = 1'b1;
                    nxt.return_address  = req.pc;
                    res.next_pc         = cfg.handler_address;
                    res.interrupt_taken = 1'b1;
                end
            end
            OP_RETURN:
            begin
                res.next_pc  = cur.return_address;
                nxt.handling = 1'b0;
            end
            OP_CLEAR:
            begin
                nxt.pending_status = cur.pending_status & ~req.clear_mask;
            end
            default:
            begin
                // Unused code: nothing changes.
            end
        endcase

        res.status_out    = nxt.pending_status;
        res.timer_out     = nxt.timer_count;
        res.busy_handling = nxt.handling;
    end

endmodule

// ----- hw/rtl/interrupt_and_timer_unit_core.sv -----
// ============================================================================
// interrupt_and_timer_unit_core
// Interrupt unit with an interval timer, stepped once per processor cycle.
// ============================================================================
//
//   Channel   Direction  Handshake           Payload
//   --------  ---------  ------------------  ---------------------------------
//   in        into core  in_valid/in_ready   itu_in_t  (operation, pc, ...)
//   out       from core  out_valid/out_ready itu_out_t (next_pc, status, ...)
//   APB       into core  psel/penable/pready 4 registers at byte 0x0..0xC
//
// A request is captured in an input register. The step logic then updates
// the timer, status and handler state and loads the result register, which
// drives out_item; this happens only once the result register is empty or
// is being emptied.
// One request is accepted every clock as long as results are taken; the
// read-modify-write of the unit state in the step logic sets that rate.
// When the result register is full and not taken, the input register keeps
// its request and in_ready stays low until the result is taken.
// Reset clears the state, the configuration registers and the valid flags of both stages.
// ============================================================================
module interrupt_and_timer_unit_core (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  itu_pkg::itu_in_t                     in_item,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output itu_pkg::itu_out_t                    out_item,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [itu_pkg::CfgAddrWidth-1:0]     paddr,
    input  logic [itu_pkg::CfgDataWidth-1:0]     pwdata,
    output logic [itu_pkg::CfgDataWidth-1:0]     prdata,
    output logic                                 pready
);
    import itu_pkg::*;

    // Configuration registers.
    itu_cfg_t   cfg_reg;
    // Architectural state of the unit.
    itu_state_t state_reg;
    itu_state_t state_next;
    // Input register stage.
    logic       req_valid_reg;
    itu_in_t    req_reg;
    // Result register stage.
    logic       res_valid_reg;
    itu_out_t   res_reg;
    itu_out_t   res_next;

    logic       advance;
    logic       cfg_write;
    logic [1:0] cfg_index;

    // The input stage moves into the result register whenever that register
    // is empty or is being emptied in this cycle.
    assign advance  = req_valid_reg && (!res_valid_reg || out_ready);
    assign in_ready = !req_valid_reg || advance;

    assign out_valid = res_valid_reg;
    assign out_item  = res_reg;

    assign pready    = 1'b1;
    assign cfg_index = paddr[CfgAddrWidth-1:2];
    assign cfg_write = psel && penable && pwrite;

    itu_step u_step (
        .cfg (cfg_reg),
        .cur (state_reg),
        .req (req_reg),
        .nxt (state_next),
        .res (res_next)
    );

    // Register reads return the stored value, zero-extended to the bus.
    always_comb
    begin
        unique case (cfg_index)
            REG_TIMER_ENABLE:    prdata = {{(CfgDataWidth-1){1'b0}}, cfg_reg.timer_enable};
            REG_TIMER_LIMIT:     prdata = cfg_reg.timer_limit;
            REG_IRQ_ENABLE_MASK:
                prdata = {{(CfgDataWidth-StatusWidth){1'b0}}, cfg_reg.irq_enable_mask};
            REG_HANDLER_ADDRESS:
                prdata = {{(CfgDataWidth-PcWidth){1'b0}}, cfg_reg.handler_address};
            default:             prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_TIMER_ENABLE:    cfg_reg.timer_enable    <= pwdata[0];
                REG_TIMER_LIMIT:     cfg_reg.timer_limit     <= pwdata;
                REG_IRQ_ENABLE_MASK: cfg_reg.irq_enable_mask <= pwdata[StatusWidth-1:0];
                REG_HANDLER_ADDRESS: cfg_reg.handler_address <= pwdata[PcWidth-1:0];
                default:             cfg_reg <= cfg_reg;
            endcase
        end
    end

    // Control and unit state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            if (in_ready)
            begin
                req_valid_reg <= in_valid;
            end
            if (advance)
            begin
                res_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end
            else if (out_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            req_reg <= in_item;
        end
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

endmodule

// ----- hw/rtl/itu_checker.sv -----
// ============================================================================
// itu_checker
// Port-level assertions for the interrupt and timer unit, bound to the core.
// ============================================================================
module itu_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             in_ready,
    input logic                             out_valid,
    input logic                             out_ready,
    input itu_pkg::itu_out_t                out_item
);
    import itu_pkg::*;

    // A waiting result must hold still until it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_item))
        else $error("result changed while stalled");

    // The core only refuses requests when a result is waiting downstream.
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("request refused without output backpressure");

    // Entering the handler leaves the handler marked as running.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.interrupt_taken |-> out_item.busy_handling)
        else $error("interrupt taken but handler not running");

    // An interrupt is only taken on a pending status bit.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.interrupt_taken |-> out_item.status_out != '0)
        else $error("interrupt taken with no pending status");

endmodule

bind interrupt_and_timer_unit_core itu_checker u_itu_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
);
